/* rtl/pftb_pkg.sv */
// Shared constants and codes of the palette fade-to-black block.
package pftb_pkg;

	localparam int COMP_W   = 10;
	localparam int IDX_W    = 6;
	localparam int MODE_W   = 2;
	localparam int CFG_W    = 32;
	localparam int CNT_W    = 7;
	localparam int PADDR_W  = 3;
	localparam int DIV_W    = 32;

	localparam logic [COMP_W-1:0] COMP_MAX = COMP_W'(1000);

	localparam int PALETTE_SIZE_DEF = 16;

	localparam logic [CFG_W-1:0] FADE_TICKS_RST = CFG_W'(1000);
	localparam logic [CNT_W-1:0] ENTRIES_RST    = CNT_W'(16);

	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_START = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_FADE_TICKS = 1'b0;
	localparam logic REG_ENTRIES    = 1'b1;

	function automatic logic [COMP_W-1:0] sat_comp(input logic [COMP_W-1:0] v);
		return (v > COMP_MAX) ? COMP_MAX : v;
	endfunction

endpackage

/* rtl/pftb_in_if.sv */
// Command channel: load, start and tick beats.
interface pftb_in_if;
	import pftb_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  entry_index;
	logic [COMP_W-1:0] red_in;
	logic [COMP_W-1:0] green_in;
	logic [COMP_W-1:0] blue_in;

	modport source (output valid, mode, entry_index, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, mode, entry_index, red_in, green_in, blue_in,
		output ready);
endinterface

/* rtl/pftb_out_if.sv */
// Result channel: one beat per palette entry to program.
interface pftb_out_if;
	import pftb_pkg::*;

	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  out_index;
	logic [COMP_W-1:0] red_out;
	logic [COMP_W-1:0] green_out;
	logic [COMP_W-1:0] blue_out;
	logic              fade_done;
	logic              last_entry;

	modport source (output valid, out_index, red_out, green_out, blue_out,
		fade_done, last_entry, input ready);
	modport sink (input valid, out_index, red_out, green_out, blue_out,
		fade_done, last_entry, output ready);
endinterface

/* rtl/palette_fade_to_black.sv */
// Palette fade to black: top level with palette RAM, sequencer and divider lanes.
// Load beat: written straight into the palette. Start beat: no division if all maxima are zero, else
// one division of fade_ticks by the largest maximum. Tick beat while fading: elapsed/step_length, then per entry
//   a RAM read, a 20-bit radix-2 division in three lanes and an output load,
//   or a RAM read and a pass-through of the stored colors on the restoring run.
// One command beat in flight at a time; the output register lets the next command in.
// arst_n clears the sequencer, configuration, fade state and output valid; the palette RAM keeps no reset value.
module palette_fade_to_black #(
	parameter int PALETTE_SIZE = pftb_pkg::PALETTE_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	pftb_in_if.sink                      cmd,
	pftb_out_if.source                   res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pftb_pkg::PADDR_W-1:0] paddr,
	input  logic [pftb_pkg::CFG_W-1:0]   pwdata,
	output logic [pftb_pkg::CFG_W-1:0]   prdata,
	output logic                         pready
);
	import pftb_pkg::*;

	localparam int PIDX_W = $clog2(PALETTE_SIZE);
	localparam int NCNT_W = PIDX_W + 1;
	localparam int PAL_W  = 3 * COMP_W;
	localparam int DCW    = $clog2(DIV_W + 1);
	localparam int LANES  = 3;

	// one-hot sequencer
	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_START_DIV = 7'b0000010,
		S_TICK_DIV  = 7'b0000100,
		S_READ      = 7'b0001000,
		S_SCALE     = 7'b0010000,
		S_SCALE_DIV = 7'b0100000,
		S_EMIT      = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [CFG_W-1:0] fade_ticks_q;
	logic [CNT_W-1:0] entries_q;

	// fade state
	logic [COMP_W-1:0] max_r_q, max_g_q, max_b_q;
	logic [COMP_W-1:0] step_count_q;
	logic [DIV_W-1:0]  step_len_q;
	logic [DIV_W-1:0]  elapsed_q;
	logic              active_q;

	// per-tick run
	logic [PIDX_W-1:0] p_q;
	logic [NCNT_W-1:0] n_q;
	logic              done_q;
	logic [COMP_W-1:0] k_q;
	logic [COMP_W-1:0] res_c_q [LANES];

	// output register
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [COMP_W-1:0] out_r_q, out_g_q, out_b_q;
	logic              out_done_q, out_last_q;

	// command decode
	logic              cmd_fire, is_load, is_start, is_tick, load_ok;
	logic [COMP_W-1:0] ld_r, ld_g, ld_b;
	logic [COMP_W-1:0] s_max;
	logic [NCNT_W-1:0] n_clamp;

	// divider lanes
	logic              div_start;
	logic [DCW-1:0]    div_iters;
	logic [DIV_W-1:0]  div_divisor;
	logic [DIV_W-1:0]  div_dividend [LANES];
	logic [LANES-1:0]  div_busy;
	logic [DIV_W-1:0]  div_quo [LANES];

	// palette RAM
	logic [PAL_W-1:0]  ram_rdata;
	logic [COMP_W-1:0] rd_c [LANES];

	logic              cfg_wr;
	logic [DIV_W:0]    tick_iter;
	logic              tick_done;
	logic              last_p, out_free, out_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_FADE_TICKS: prdata = fade_ticks_q;
			REG_ENTRIES:    prdata = CFG_W'(entries_q);
			default:        prdata = '0;
		endcase
	end

	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign is_load   = cmd_fire && (cmd.mode == MODE_LOAD);
	assign is_start  = cmd_fire && (cmd.mode == MODE_START);
	// a tick while no fade is active is swallowed
	assign is_tick   = cmd_fire && (cmd.mode == MODE_TICK) && active_q;

	assign ld_r    = sat_comp(cmd.red_in);
	assign ld_g    = sat_comp(cmd.green_in);
	assign ld_b    = sat_comp(cmd.blue_in);
	// indexes past the palette are dropped
	assign load_ok = is_load && ({1'b0, cmd.entry_index} < (IDX_W + 1)'(PALETTE_SIZE));

	always_comb begin
		s_max = max_r_q;
		if (max_g_q > s_max) s_max = max_g_q;
		if (max_b_q > s_max) s_max = max_b_q;
	end

	always_comb begin
		priority if (entries_q == '0) begin
			n_clamp = NCNT_W'(1);
		end else if (entries_q > CNT_W'(PALETTE_SIZE)) begin
			n_clamp = NCNT_W'(PALETTE_SIZE);
		end else begin
			n_clamp = entries_q[NCNT_W-1:0];
		end
	end

	// iter = elapsed / step_length + 1, from lane 0
	assign tick_iter = {1'b0, div_quo[0]} + (DIV_W + 1)'(1);
	assign tick_done = tick_iter > (DIV_W + 1)'(step_count_q);

	assign rd_c[0] = ram_rdata[3*COMP_W-1:2*COMP_W];
	assign rd_c[1] = ram_rdata[2*COMP_W-1:COMP_W];
	assign rd_c[2] = ram_rdata[COMP_W-1:0];

	// divider operand steering
	always_comb begin
		div_start   = 1'b0;
		div_iters   = DCW'(DIV_W);
		div_divisor = DIV_W'(step_count_q);
		for (int l = 0; l < LANES; l++) begin
			div_dividend[l] = DIV_W'((2 * COMP_W)'(rd_c[l]) * (2 * COMP_W)'(k_q));
		end
		priority if (state_q == S_SCALE) begin
			div_start = !done_q;
			div_iters = DCW'(2 * COMP_W);
		end else if (is_start) begin
			div_start       = (s_max != '0);
			div_dividend[0] = fade_ticks_q;
			div_divisor     = DIV_W'(s_max);
		end else if (is_tick) begin
			div_start       = 1'b1;
			div_dividend[0] = elapsed_q;
			div_divisor     = step_len_q;
		end else begin
			div_start = 1'b0;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		pftb_div #(.W(DIV_W)) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.iters    (div_iters),
			.dividend (div_dividend[l]),
			.divisor  (div_divisor),
			.busy     (div_busy[l]),
			.quotient (div_quo[l])
		);
	end

	pftb_ram #(.WIDTH(PAL_W), .DEPTH(PALETTE_SIZE)) u_pal (
		.clk   (clk),
		.we    (load_ok),
		.waddr (cmd.entry_index[PIDX_W-1:0]),
		.wdata ({ld_r, ld_g, ld_b}),
		.re    (state_q == S_READ),
		.raddr (p_q),
		.rdata (ram_rdata)
	);

	assign last_p   = (NCNT_W'(p_q) + NCNT_W'(1)) == n_q;
	assign out_free = !out_valid_q || res.ready;
	assign out_load = (state_q == S_EMIT) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (is_start && (s_max != '0)) state_d = S_START_DIV;
				else if (is_tick)              state_d = S_TICK_DIV;
			end
			S_START_DIV: if (!div_busy[0]) state_d = S_IDLE;
			S_TICK_DIV:  if (!div_busy[0]) state_d = S_READ;
			S_READ:      state_d = S_SCALE;
			S_SCALE:     state_d = done_q ? S_EMIT : S_SCALE_DIV;
			S_SCALE_DIV: if (div_busy == '0) state_d = S_EMIT;
			S_EMIT:      if (out_free) state_d = last_p ? S_IDLE : S_READ;
			default:     state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fade_ticks_q <= FADE_TICKS_RST;
			entries_q    <= ENTRIES_RST;
			max_r_q      <= '0;
			max_g_q      <= '0;
			max_b_q      <= '0;
			step_count_q <= '0;
			step_len_q   <= DIV_W'(1);
			elapsed_q    <= '0;
			active_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_wr) begin
				unique case (paddr[2])
					REG_FADE_TICKS: fade_ticks_q <= pwdata;
					REG_ENTRIES:    entries_q    <= pwdata[CNT_W-1:0];
					default:        ;
				endcase
			end

			if (load_ok) begin
				if (ld_r > max_r_q) max_r_q <= ld_r;
				if (ld_g > max_g_q) max_g_q <= ld_g;
				if (ld_b > max_b_q) max_b_q <= ld_b;
			end

			if (is_start) begin
				step_count_q <= s_max;
				elapsed_q    <= '0;
				active_q     <= 1'b1;
				// no steps: the whole duration is one step
				if (s_max == '0) begin
					step_len_q <= (fade_ticks_q == '0) ? DIV_W'(1) : fade_ticks_q;
				end
			end

			if ((state_q == S_START_DIV) && !div_busy[0]) begin
				step_len_q <= (div_quo[0] == '0) ? DIV_W'(1) : div_quo[0];
			end

			if ((state_q == S_TICK_DIV) && !div_busy[0]) begin
				if (tick_done) begin
					active_q <= 1'b0;
				end else if (elapsed_q != '1) begin
					elapsed_q <= elapsed_q + DIV_W'(1);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_tick) begin
			p_q <= '0;
			n_q <= n_clamp;
		end
		if ((state_q == S_TICK_DIV) && !div_busy[0]) begin
			done_q <= tick_done;
			k_q    <= step_count_q - tick_iter[COMP_W-1:0];
		end
		// restoring run passes the stored colors straight through
		if ((state_q == S_SCALE) && done_q) begin
			for (int l = 0; l < LANES; l++) res_c_q[l] <= rd_c[l];
		end
		if ((state_q == S_SCALE_DIV) && (div_busy == '0)) begin
			for (int l = 0; l < LANES; l++) res_c_q[l] <= div_quo[l][COMP_W-1:0];
		end
		if (out_load) begin
			out_index_q <= IDX_W'(p_q);
			out_r_q     <= res_c_q[0];
			out_g_q     <= res_c_q[1];
			out_b_q     <= res_c_q[2];
			out_done_q  <= done_q;
			out_last_q  <= last_p;
			if (!last_p) p_q <= p_q + PIDX_W'(1);
		end
	end

	assign res.valid      = out_valid_q;
	assign res.out_index  = out_index_q;
	assign res.red_out    = out_r_q;
	assign res.green_out  = out_g_q;
	assign res.blue_out   = out_b_q;
	assign res.fade_done  = out_done_q;
	assign res.last_entry = out_last_q;

	// step length is clamped to one everywhere it is written
	a_step_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		step_len_q != '0)
		else $error("step length is zero");

	// scaling divides by the step count, which is nonzero on a fading tick
	a_scale_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCALE && !done_q) |-> (step_count_q != '0))
		else $error("scale division by zero step count");

	// a restoring run only emits after the fade has been switched off
	a_done_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && done_q) |-> !active_q)
		else $error("restored palette emitted while still fading");

	// no new command while dividers are still working on the previous one
	a_ready_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (div_busy == '0))
		else $error("command taken while a division is running");

endmodule

/* rtl/pftb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module pftb_ram #(
	parameter int WIDTH = 30,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/pftb_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, variable bit count.
module pftb_div #(
	parameter int W = 32,
	localparam int CW = $clog2(W + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] iters,
	input  logic [W-1:0]  dividend,
	input  logic [W-1:0]  divisor,
	output logic          busy,
	output logic [W-1:0]  quotient
);
	logic [CW-1:0] count_q;
	logic          busy_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  q_q;
	logic [W-1:0]  d_q;
	logic [W:0]    trial;

	// top bits of the dividend beyond iters are known zero: skip them
	assign trial = {a_q, q_q[W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			count_q <= iters;
		end else if (busy_q) begin
			count_q <= count_q - CW'(1);
			busy_q  <= (count_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= '0;
			q_q <= dividend << (CW'(W) - iters);
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				a_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				a_q <= {a_q[W-2:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = q_q;
endmodule
